// ----- rtl/core/lcdst_pkg.sv -----
// Shared types, codes and timing constants of the LCD sweep timing and status block.
`timescale 1ns / 1ps
`default_nettype none

package lcdst_pkg;

    localparam int DOTS_PER_LINE = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;
    localparam int OAM_SCAN_DOTS = 80;
    localparam int DRAWING_DOTS  = 172;

    localparam logic [8:0] LINE_END_DOT  = 9'(DOTS_PER_LINE);
    localparam logic [8:0] DRAW_START    = 9'(OAM_SCAN_DOTS);
    localparam logic [9:0] DRAW_END      = 10'(OAM_SCAN_DOTS + DRAWING_DOTS);
    localparam logic [7:0] VBLANK_LINE   = 8'(VISIBLE_LINES);
    localparam logic [7:0] LINE_WRAP     = 8'(TOTAL_LINES);

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] MD_HBLANK = 2'd0;
    localparam logic [1:0] MD_VBLANK = 2'd1;
    localparam logic [1:0] MD_OAM    = 2'd2;
    localparam logic [1:0] MD_DRAW   = 2'd3;

    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_SCY  = 4'd2;
    localparam logic [3:0] REG_SCX  = 4'd3;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;
    localparam logic [3:0] REG_BGP  = 4'd7;
    localparam logic [3:0] REG_OBP0 = 4'd8;
    localparam logic [3:0] REG_OBP1 = 4'd9;
    localparam logic [3:0] REG_WY   = 4'd10;
    localparam logic [3:0] REG_WX   = 4'd11;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [7:0] OBP_RESET  = 8'hFF;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] reg_offset;
        logic [7:0] wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] ppu_mode;
        logic [7:0] line_count;
        logic       vblank_pulse;
        logic       stat_pulse;
        logic       compose_line;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/lcdst_sweep.sv -----
// Sweep state, register file and per-beat result logic.
`timescale 1ns / 1ps
`default_nettype none

module lcdst_sweep
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire lcdst_pkg::item_t item,
    output lcdst_pkg::result_t    result
);
    import lcdst_pkg::*;

    logic [7:0] ctrl_reg, ctrl_next;
    logic [3:0] sel_reg, sel_next;
    logic [7:0] scy_reg, scy_next;
    logic [7:0] scx_reg, scx_next;
    logic [7:0] lyc_reg, lyc_next;
    logic [7:0] bgp_reg, bgp_next;
    logic [7:0] obp0_reg, obp0_next;
    logic [7:0] obp1_reg, obp1_next;
    logic [7:0] wy_reg, wy_next;
    logic [7:0] wx_reg, wx_next;
    logic [7:0] ly_reg, ly_next;
    logic [8:0] dot_reg, dot_next;
    logic [1:0] mode_reg, mode_next;
    logic       lvl_reg, lvl_next;

    function automatic logic [1:0] stat_eval(input logic on, input logic [3:0] sel,
                                             input logic [7:0] ly, input logic [7:0] lyc,
                                             input logic [1:0] md, input logic prev);
        logic lvl;
        lvl = on && ((sel[3] && (ly == lyc)) || (sel[0] && (md == MD_HBLANK)) ||
                     (sel[1] && (md == MD_VBLANK)) || (sel[2] && (md == MD_OAM)));
        return {lvl, lvl && !prev};
    endfunction

    always_comb
    begin
        logic       on;
        logic [8:0] dot_w;
        logic [7:0] ly_w;
        logic [1:0] md_w;
        logic       lvl_w;
        logic [1:0] ev;
        logic       stat_w;
        logic       vbl_w;
        logic       cmp_w;
        logic [7:0] rd_w;

        on        = ctrl_reg[7];
        ctrl_next = ctrl_reg;
        sel_next  = sel_reg;
        scy_next  = scy_reg;
        scx_next  = scx_reg;
        lyc_next  = lyc_reg;
        bgp_next  = bgp_reg;
        obp0_next = obp0_reg;
        obp1_next = obp1_reg;
        wy_next   = wy_reg;
        wx_next   = wx_reg;
        ly_next   = ly_reg;
        dot_next  = dot_reg;
        mode_next = mode_reg;
        lvl_next  = lvl_reg;
        dot_w     = dot_reg;
        ly_w      = ly_reg;
        md_w      = mode_reg;
        lvl_w     = lvl_reg;
        ev        = 2'b00;
        stat_w    = 1'b0;
        vbl_w     = 1'b0;
        cmp_w     = 1'b0;
        rd_w      = OPEN_BUS;

        if (item_valid)
        begin
            case (item.kind)
                KIND_TICK:
                begin
                    if (on)
                    begin
                        dot_w = dot_reg + 9'd1;
                        if (ly_reg < VBLANK_LINE)
                        begin
                            if (dot_w == DRAW_START)
                            begin
                                md_w   = MD_DRAW;
                                ev     = stat_eval(1'b1, sel_reg, ly_reg, lyc_reg, md_w, lvl_w);
                                lvl_w  = ev[1];
                                stat_w = stat_w | ev[0];
                            end
                            else if ({1'b0, dot_w} == DRAW_END)
                            begin
                                cmp_w  = 1'b1;
                                md_w   = MD_HBLANK;
                                ev     = stat_eval(1'b1, sel_reg, ly_reg, lyc_reg, md_w, lvl_w);
                                lvl_w  = ev[1];
                                stat_w = stat_w | ev[0];
                            end
                        end
                        if (dot_w >= LINE_END_DOT)
                        begin
                            dot_w = 9'd0;
                            ly_w  = ly_reg + 8'd1;
                            if (ly_w == VBLANK_LINE)
                            begin
                                md_w  = MD_VBLANK;
                                vbl_w = 1'b1;
                            end
                            else if (ly_w >= LINE_WRAP)
                            begin
                                ly_w = 8'd0;
                                md_w = MD_OAM;
                            end
                            else if (ly_w < VBLANK_LINE)
                            begin
                                md_w = MD_OAM;
                            end
                            ev     = stat_eval(1'b1, sel_reg, ly_w, lyc_reg, md_w, lvl_w);
                            lvl_w  = ev[1];
                            stat_w = stat_w | ev[0];
                        end
                        dot_next  = dot_w;
                        ly_next   = ly_w;
                        mode_next = md_w;
                        lvl_next  = lvl_w;
                    end
                end
                KIND_READ:
                begin
                    case (item.reg_offset)
                        REG_LCDC: rd_w = ctrl_reg;
                        REG_STAT: rd_w = {1'b1, sel_reg, (ly_reg == lyc_reg),
                                          (on ? mode_reg : MD_HBLANK)};
                        REG_SCY:  rd_w = scy_reg;
                        REG_SCX:  rd_w = scx_reg;
                        REG_LY:   rd_w = on ? ly_reg : 8'd0;
                        REG_LYC:  rd_w = lyc_reg;
                        REG_BGP:  rd_w = bgp_reg;
                        REG_OBP0: rd_w = obp0_reg;
                        REG_OBP1: rd_w = obp1_reg;
                        REG_WY:   rd_w = wy_reg;
                        REG_WX:   rd_w = wx_reg;
                        default:  rd_w = OPEN_BUS;
                    endcase
                end
                KIND_WRITE:
                begin
                    case (item.reg_offset)
                        REG_LCDC:
                        begin
                            ctrl_next = item.wdata;
                            if (on && !item.wdata[7])
                            begin
                                ly_next   = 8'd0;
                                dot_next  = 9'd0;
                                mode_next = MD_HBLANK;
                                lvl_next  = 1'b0;
                            end
                            else if (!on && item.wdata[7])
                            begin
                                ly_next   = 8'd0;
                                dot_next  = 9'd0;
                                mode_next = MD_OAM;
                                ev        = stat_eval(1'b1, sel_reg, 8'd0, lyc_reg, MD_OAM,
                                                      lvl_reg);
                                lvl_next  = ev[1];
                                stat_w    = ev[0];
                            end
                        end
                        REG_STAT:
                        begin
                            sel_next = item.wdata[6:3];
                            ev       = stat_eval(on, item.wdata[6:3], ly_reg, lyc_reg, mode_reg,
                                                 lvl_reg);
                            lvl_next = ev[1];
                            stat_w   = ev[0];
                        end
                        REG_SCY:  scy_next = item.wdata;
                        REG_SCX:  scx_next = item.wdata;
                        REG_LYC:
                        begin
                            lyc_next = item.wdata;
                            ev       = stat_eval(on, sel_reg, ly_reg, item.wdata, mode_reg,
                                                 lvl_reg);
                            lvl_next = ev[1];
                            stat_w   = ev[0];
                        end
                        REG_BGP:  bgp_next  = item.wdata;
                        REG_OBP0: obp0_next = item.wdata;
                        REG_OBP1: obp1_next = item.wdata;
                        REG_WY:   wy_next   = item.wdata;
                        REG_WX:   wx_next   = item.wdata;
                        default:  ;
                    endcase
                end
                default: ;
            endcase
        end

        result.rdata        = rd_w;
        result.ppu_mode     = ctrl_next[7] ? mode_next : MD_HBLANK;
        result.line_count   = ctrl_next[7] ? ly_next : 8'd0;
        result.vblank_pulse = vbl_w;
        result.stat_pulse   = stat_w;
        result.compose_line = cmp_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= LCDC_RESET;
            sel_reg  <= 4'd0;
            scy_reg  <= 8'd0;
            scx_reg  <= 8'd0;
            lyc_reg  <= 8'd0;
            bgp_reg  <= BGP_RESET;
            obp0_reg <= OBP_RESET;
            obp1_reg <= OBP_RESET;
            wy_reg   <= 8'd0;
            wx_reg   <= 8'd0;
            ly_reg   <= 8'd0;
            dot_reg  <= 9'd0;
            mode_reg <= MD_OAM;
            lvl_reg  <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            sel_reg  <= sel_next;
            scy_reg  <= scy_next;
            scx_reg  <= scx_next;
            lyc_reg  <= lyc_next;
            bgp_reg  <= bgp_next;
            obp0_reg <= obp0_next;
            obp1_reg <= obp1_next;
            wy_reg   <= wy_next;
            wx_reg   <= wx_next;
            ly_reg   <= ly_next;
            dot_reg  <= dot_next;
            mode_reg <= mode_next;
            lvl_reg  <= lvl_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lcd_sweep_timing_and_status_top.sv -----
// Top level of the LCD sweep timing and status block: stream ports and beat staging.
//
// Channel  Dir  Payload                                          Beat when
// s_*      in   tuser: mode; tdata: reg_offset, wdata            s_tvalid && s_tready
// m_*      out  tdata: rdata, ppu_mode, line_count, pulses       m_tvalid && m_tready
//
// One beat per cycle sustained while m_tready is high; a result passes the input register,
// then the sweep logic into the result register, before it leaves.
// rst_n clears both stages and loads the register file and sweep to their reset values.
// A stalled result holds; the input stage takes one more beat, then holds s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module lcd_sweep_timing_and_status_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [3:0] reg_offset, [11:4] wdata, [15:12] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [7:0] rdata, [9:8] ppu_mode, [17:10] line_count,
                                        // [18] vblank_pulse, [19] stat_pulse,
                                        // [20] compose_line, [23:21] zero
);
    import lcdst_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t res;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    lcdst_sweep u_sweep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item       (in_item_reg),
        .result     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.kind       <= s_tuser;
            in_item_reg.reg_offset <= s_tdata[3:0];
            in_item_reg.wdata      <= s_tdata[11:4];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.compose_line, out_res_reg.stat_pulse,
                       out_res_reg.vblank_pulse, out_res_reg.line_count,
                       out_res_reg.ppu_mode, out_res_reg.rdata};

endmodule

`default_nettype wire
